/* sv/tape_file_header_parser_core_defines.svh */
// Assertion macros for the tape file header parser.
// Included by the checker file; no other dependencies.
`ifndef TAPE_FILE_HEADER_PARSER_CORE_DEFINES_SVH
`define TAPE_FILE_HEADER_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFHP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TFHP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/tfhp_pkg.sv */
// Types and constants for the tape file header parser.
// No dependencies; used by the parser modules and the checker.
package tfhp_pkg;

    localparam int CNT_W = 5;

    // Commands of an input item
    localparam logic [1:0] CMD_SYNC = 2'd0;
    localparam logic [1:0] CMD_DATA = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_NAME   = 2'd1;
    localparam logic [1:0] KIND_BODY   = 2'd2;
    localparam logic [1:0] KIND_ABORT  = 2'd3;

    // Tape byte values
    localparam logic [7:0] SYNC_BYTE    = 8'h16;
    localparam logic [7:0] START_BYTE   = 8'h24;
    localparam logic [7:0] NULL_BYTE    = 8'h00;
    localparam logic [7:0] TYPE_BASIC   = 8'h00;
    localparam logic [7:0] TYPE_MCODE   = 8'h80;
    localparam logic [7:0] LAUNCH_BASIC = 8'h80;
    localparam logic [7:0] LAUNCH_MCODE = 8'hC7;

    // Decoded type codes
    localparam logic [1:0] TYPE_KIND_NONE  = 2'd0;
    localparam logic [1:0] TYPE_KIND_BASIC = 2'd1;
    localparam logic [1:0] TYPE_KIND_MCODE = 2'd2;

    // Header byte positions after the start byte
    localparam logic [CNT_W-1:0] HDR_DATA_TYPE   = 5'd2;
    localparam logic [CNT_W-1:0] HDR_LAUNCH_TYPE = 5'd3;
    localparam logic [CNT_W-1:0] HDR_END_HI      = 5'd4;
    localparam logic [CNT_W-1:0] HDR_END_LO      = 5'd5;
    localparam logic [CNT_W-1:0] HDR_START_HI    = 5'd6;
    localparam logic [CNT_W-1:0] HDR_START_LO    = 5'd7;
    localparam logic [CNT_W-1:0] HDR_LAST        = 5'd8;

    typedef enum logic [6:0] {
        PH_WAIT   = 7'b000_0001,
        PH_SYNC1  = 7'b000_0010,
        PH_SYNC2  = 7'b000_0100,
        PH_SKIP   = 7'b000_1000,
        PH_HEADER = 7'b001_0000,
        PH_NAME   = 7'b010_0000,
        PH_BODY   = 7'b100_0000
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic [CNT_W-1:0]  field_count;
        logic              speed;
        logic [15:0]       end_addr;
        logic [15:0]       start_addr;
        logic [1:0]        data_kind;
        logic [1:0]        launch_kind;
        logic [16:0]       body_remaining;
        logic [15:0]       body_index;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [15:0] body_offset;
        logic        last_byte;
        logic [1:0]  data_kind;
        logic [1:0]  launch_kind;
        logic [15:0] start_address;
        logic [15:0] end_address;
        logic        speed_out;
    } result_t;

endpackage

/* sv/tfhp_if.sv */
// Valid/ready channel interfaces for tape events and parser results.
// No dependencies.
interface tfhp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       fast_speed;

    modport source (output valid, command, data_byte, fast_speed, input ready);
    modport sink   (input valid, command, data_byte, fast_speed, output ready);
endinterface

interface tfhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] body_offset;
    logic        last_byte;
    logic [1:0]  data_kind;
    logic [1:0]  launch_kind;
    logic [15:0] start_address;
    logic [15:0] end_address;
    logic        speed_out;

    modport source (output valid, kind, byte_value, body_offset, last_byte, data_kind,
                    launch_kind, start_address, end_address, speed_out, input ready);
    modport sink   (input valid, kind, byte_value, body_offset, last_byte, data_kind,
                    launch_kind, start_address, end_address, speed_out, output ready);
endinterface

/* sv/tfhp_step.sv */
// Next-state and result logic of the tape file parser for one item.
// Depends on tfhp_pkg.
module tfhp_step
    import tfhp_pkg::*;
#(
    parameter int NAME_MAX = 16
)
(
    input  parse_state_t cur,
    input  logic [1:0]   command,
    input  logic [7:0]   data_byte,
    input  logic         fast_speed,
    output parse_state_t nxt,
    output logic         emit,
    output result_t      res
);

    logic              in_file;
    logic [CNT_W:0]    name_count;
    logic [15:0]       body_len;
    logic              body_last;

    assign in_file    = (cur.phase == PH_HEADER) || (cur.phase == PH_NAME) ||
                        (cur.phase == PH_BODY);
    assign name_count = {1'b0, cur.field_count} + {{CNT_W{1'b0}}, 1'b1};
    assign body_len   = cur.end_addr - cur.start_addr + 16'd1;
    assign body_last  = (cur.body_remaining <= 17'd1);

    always_comb
    begin
        nxt  = cur;
        emit = 1'b0;
        // header fields always show the stored values
        res.kind          = KIND_ABORT;
        res.byte_value    = 8'd0;
        res.body_offset   = 16'd0;
        res.last_byte     = 1'b0;
        res.data_kind     = cur.data_kind;
        res.launch_kind   = cur.launch_kind;
        res.start_address = cur.start_addr;
        res.end_address   = cur.end_addr;
        res.speed_out     = cur.speed;

        case (command)
            CMD_SYNC:
            begin
                emit            = in_file;
                nxt.speed       = fast_speed;
                nxt.field_count = '0;
                nxt.phase       = PH_SYNC1;
            end
            CMD_END:
            begin
                emit            = in_file;
                nxt.field_count = '0;
                nxt.phase       = PH_WAIT;
            end
            CMD_DATA:
            begin
                case (cur.phase)
                    PH_SYNC1:
                        nxt.phase = (data_byte == SYNC_BYTE) ? PH_SYNC2 : PH_WAIT;
                    PH_SYNC2:
                        nxt.phase = (data_byte == SYNC_BYTE) ? PH_SKIP : PH_WAIT;
                    PH_SKIP:
                    begin
                        if (data_byte == START_BYTE)
                        begin
                            nxt.field_count = '0;
                            nxt.phase       = PH_HEADER;
                        end
                        else if (data_byte != SYNC_BYTE)
                        begin
                            nxt.phase = PH_WAIT;
                        end
                    end
                    PH_HEADER:
                    begin
                        case (cur.field_count)
                            HDR_DATA_TYPE:
                                nxt.data_kind = (data_byte == TYPE_BASIC) ? TYPE_KIND_BASIC :
                                                (data_byte == TYPE_MCODE) ? TYPE_KIND_MCODE :
                                                TYPE_KIND_NONE;
                            HDR_LAUNCH_TYPE:
                                nxt.launch_kind = (data_byte == LAUNCH_BASIC) ? TYPE_KIND_BASIC :
                                                  (data_byte == LAUNCH_MCODE) ? TYPE_KIND_MCODE :
                                                  TYPE_KIND_NONE;
                            HDR_END_HI:   nxt.end_addr[15:8]   = data_byte;
                            HDR_END_LO:   nxt.end_addr[7:0]    = data_byte;
                            HDR_START_HI: nxt.start_addr[15:8] = data_byte;
                            HDR_START_LO: nxt.start_addr[7:0]  = data_byte;
                            default: ;
                        endcase
                        if (cur.field_count >= HDR_LAST)
                        begin
                            // zero length wraps to a full 64K body
                            nxt.body_remaining = (body_len == 16'd0) ? 17'h10000
                                                                      : {1'b0, body_len};
                            nxt.body_index  = 16'd0;
                            nxt.field_count = '0;
                            nxt.phase       = PH_NAME;
                            emit            = 1'b1;
                            res.kind        = KIND_HEADER;
                        end
                        else
                        begin
                            nxt.field_count = name_count[CNT_W-1:0];
                        end
                    end
                    PH_NAME:
                    begin
                        if (data_byte == NULL_BYTE)
                        begin
                            nxt.field_count = '0;
                            nxt.phase       = PH_BODY;
                        end
                        else
                        begin
                            emit            = 1'b1;
                            res.kind        = KIND_NAME;
                            res.byte_value  = data_byte;
                            nxt.field_count = name_count[CNT_W-1:0];
                            if (name_count >= (CNT_W+1)'(NAME_MAX))
                            begin
                                nxt.field_count = '0;
                                nxt.phase       = PH_BODY;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        emit               = 1'b1;
                        res.kind           = KIND_BODY;
                        res.byte_value     = data_byte;
                        res.body_offset    = cur.body_index;
                        res.last_byte      = body_last;
                        nxt.body_index     = cur.body_index + 16'd1;
                        nxt.body_remaining = cur.body_remaining - 17'd1;
                        if (body_last)
                        begin
                            nxt.phase = PH_WAIT;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

endmodule

/* sv/tape_file_header_parser_core.sv */
// Tape file header parser. Takes one decoded tape event per cycle when ready
// (sync, data byte, end of tape) and gives at most one result per event:
// header complete, name character, body byte with offset and last flag, or
// abort. Each item is handled in the cycle it is accepted and its result
// appears in the result register on the next cycle, so the block sustains one
// item per clock while results are taken. The result register is the only
// buffer: while it is full the input is ready only when the result is taken.
// Depends on tfhp_pkg, tfhp_if and tfhp_step.
module tape_file_header_parser_core
    import tfhp_pkg::*;
#(
    parameter int NAME_MAX = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    tfhp_in_if.sink     tape,
    tfhp_out_if.source  result
);

    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      res_reg;
    result_t      res_next;
    logic         res_valid_reg;
    logic         emit;
    logic         accept;

    assign tape.ready = !res_valid_reg || result.ready;
    assign accept     = tape.valid && tape.ready;

    tfhp_step #(
        .NAME_MAX (NAME_MAX)
    ) u_step (
        .cur        (state_reg),
        .command    (tape.command),
        .data_byte  (tape.data_byte),
        .fast_speed (tape.fast_speed),
        .nxt        (state_next),
        .emit       (emit),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase: PH_WAIT, default: '0};
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (accept && emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload loads only with a new result
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.kind          = res_reg.kind;
    assign result.byte_value    = res_reg.byte_value;
    assign result.body_offset   = res_reg.body_offset;
    assign result.last_byte     = res_reg.last_byte;
    assign result.data_kind     = res_reg.data_kind;
    assign result.launch_kind   = res_reg.launch_kind;
    assign result.start_address = res_reg.start_address;
    assign result.end_address   = res_reg.end_address;
    assign result.speed_out     = res_reg.speed_out;

endmodule

/* sv/tfhp_checker.sv */
// Port-level checks for the tape file header parser, bound to the top level.
// Depends on tfhp_pkg and tape_file_header_parser_core_defines.svh.
`include "tape_file_header_parser_core_defines.svh"

module tfhp_checker
    import tfhp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  byte_value,
    input logic [15:0] body_offset,
    input logic        last_byte
);

    `TFHP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(byte_value) && $stable(body_offset), "result changed while stalled")
    `TFHP_ASSERT_NOW(a_last_is_body, clk, rst_n, out_valid && last_byte, kind == KIND_BODY, "last flag on a non-body result")
    `TFHP_ASSERT_NOW(a_offset_body_only, clk, rst_n, out_valid && (kind != KIND_BODY), body_offset == 16'd0 && !last_byte, "body offset on a non-body result")
    `TFHP_ASSERT_NOW(a_rise_needs_item, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready), "result without an accepted item")
    `TFHP_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty result register")

endmodule

bind tape_file_header_parser_core tfhp_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (tape.valid),
    .in_ready    (tape.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .kind        (result.kind),
    .byte_value  (result.byte_value),
    .body_offset (result.body_offset),
    .last_byte   (result.last_byte)
);
